// File: design/hot_pkg.sv
// shared types and constants of the hash overflow table
package hot_pkg;

  localparam int GROUPS        = 16;
  localparam int GW            = 4;
  localparam int LANES         = 4;
  localparam int MAX_KEY_WORDS = 6;
  localparam int KW_W          = 3;
  localparam int CAP_W         = 5;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CAP_W-1:0]     CAP_RESET     = 5'd10;
  localparam logic [KW_W-1:0]      KWC_RESET     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOG2_CAP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORDS = 1'd1;

  typedef enum logic [1:0] {
    FN_GET    = 2'd0,
    FN_SET    = 2'd1,
    FN_UNSET  = 2'd2,
    FN_REFILL = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RES,
    ST_SLOT,
    ST_KRD,
    ST_KCMP,
    ST_HIT,
    ST_MISS,
    ST_GROW,
    ST_POP,
    ST_INS,
    ST_KWR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic res;
    logic hash;
    logic key;
    logic fs;
  } mem_we_t;

endpackage

// File: design/hot_store.sv
// slot result, hash, key and free stack memories
module hot_store #(
  parameter int IW = 10
) (
  input  logic                clk,
  input  hot_pkg::mem_we_t    we,
  input  logic [IW-1:0]       res_waddr,
  input  logic [31:0]         res_wdata,
  input  logic [31:0]         hash_wdata,
  input  logic [IW-1:0]       res_raddr,
  output logic [31:0]         res_q,
  output logic [31:0]         hash_q,
  input  logic [IW+2:0]       key_waddr,
  input  logic [31:0]         key_wdata,
  input  logic [IW+2:0]       key_raddr,
  output logic [31:0]         key_q,
  input  logic [IW-1:0]       fs_waddr,
  input  logic [IW-5:0]       fs_wdata,
  input  logic [IW-1:0]       fs_raddr,
  output logic [IW-5:0]       fs_q
);

  logic [31:0]   res_mem  [2**IW];
  logic [31:0]   hash_mem [2**IW];
  logic [31:0]   key_mem  [2**(IW+3)];
  logic [IW-5:0] fs_mem   [2**IW];

  always_ff @(posedge clk) begin
    if (we.res) begin
      res_mem[res_waddr] <= res_wdata;
    end
    if (we.hash) begin
      hash_mem[res_waddr] <= hash_wdata;
    end
    if (we.key) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (we.fs) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    res_q  <= res_mem[res_raddr];
    hash_q <= hash_mem[res_raddr];
    key_q  <= key_mem[key_raddr];
    fs_q   <= fs_mem[fs_raddr];
  end

endmodule

// File: design/hot_ctrl.sv
// sequencer, per-group free list counters and shared key compare
module hot_ctrl #(
  parameter int SLOTS_PER_GROUP = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  output logic                                   done,
  input  logic                                   cfg_we,
  input  logic [hot_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [hot_pkg::CAP_W-1:0]              cfg_data,
  input  logic [1:0]                             func,
  input  logic [31:0]                            lookup_hash,
  input  logic [31:0]                            store_value,
  input  logic [31:0]                            key_in [hot_pkg::MAX_KEY_WORDS],
  output logic [31:0]                            out_result,
  output logic                                   found,
  output logic                                   table_full,
  output logic [31:0]                            key_out [hot_pkg::MAX_KEY_WORDS],
  output logic [10:0]                            entry_total,
  output hot_pkg::mem_we_t                       we,
  output logic [hot_pkg::GW+$clog2(SLOTS_PER_GROUP)-1:0] res_waddr,
  output logic [31:0]                            res_wdata,
  output logic [31:0]                            hash_wdata,
  output logic [hot_pkg::GW+$clog2(SLOTS_PER_GROUP)-1:0] res_raddr,
  input  logic [31:0]                            res_q,
  input  logic [31:0]                            hash_q,
  output logic [hot_pkg::GW+$clog2(SLOTS_PER_GROUP)+2:0] key_waddr,
  output logic [31:0]                            key_wdata,
  output logic [hot_pkg::GW+$clog2(SLOTS_PER_GROUP)+2:0] key_raddr,
  input  logic [31:0]                            key_q,
  output logic [hot_pkg::GW+$clog2(SLOTS_PER_GROUP)-1:0] fs_waddr,
  output logic [$clog2(SLOTS_PER_GROUP)-1:0]     fs_wdata,
  output logic [hot_pkg::GW+$clog2(SLOTS_PER_GROUP)-1:0] fs_raddr,
  input  logic [$clog2(SLOTS_PER_GROUP)-1:0]     fs_q
);

  localparam int SW    = $clog2(SLOTS_PER_GROUP);
  localparam int BKT   = SLOTS_PER_GROUP / hot_pkg::LANES;
  localparam int BUW   = $clog2(BKT + 1);
  localparam int FDW   = $clog2(SLOTS_PER_GROUP + 1);
  localparam int TOTAL = hot_pkg::GROUPS * SLOTS_PER_GROUP;
  localparam int CW    = $clog2(TOTAL + 1);
  localparam int KW    = hot_pkg::KW_W;

  hot_pkg::state_t state, state_next;

  logic [hot_pkg::CAP_W-1:0] log2_cap;
  logic [KW-1:0]             kwc;
  logic [FDW-1:0]            fd [hot_pkg::GROUPS];
  logic [BUW-1:0]            bu [hot_pkg::GROUPS];
  logic [CW-1:0]             occ;

  hot_pkg::func_t         fn;
  logic [31:0]            h;
  logic [31:0]            nr;
  logic [31:0]            mask;
  logic [31:0]            in_key [hot_pkg::MAX_KEY_WORDS];
  logic [hot_pkg::GW-1:0] g;
  logic [KW-1:0]          n;
  logic [SW-1:0]          s;
  logic [KW-1:0]          w;
  logic [31:0]            res_out;
  logic                   found_q;
  logic                   full_q;
  logic [31:0]            kout [hot_pkg::MAX_KEY_WORDS];

  logic [hot_pkg::CAP_W-1:0] l_eff;
  logic [31:0]               mask_in;
  logic [hot_pkg::GW-1:0]    g_in;
  logic [KW-1:0]             n_in;
  logic [FDW-1:0]            fd_cur;
  logic [BUW-1:0]            bu_cur;
  logic                      last_slot;
  logic                      last_w;
  logic                      key_eq;
  logic                      hash_hit;
  logic [SW-1:0]             slot_new;
  logic                      accept;

  assign accept = start && (state == hot_pkg::ST_IDLE);

  always_comb begin
    l_eff = (log2_cap < 5'd2) ? 5'd2 : log2_cap;
    for (int k = 0; k < 32; k++) begin
      mask_in[k] = (k >= 2) && (5'(k) < l_eff);
    end
    g_in = lookup_hash[5:2] & mask_in[5:2];
    if (kwc == 3'd0) begin
      n_in = 3'd1;
    end else if (kwc > 3'(hot_pkg::MAX_KEY_WORDS)) begin
      n_in = 3'(hot_pkg::MAX_KEY_WORDS);
    end else begin
      n_in = kwc;
    end
  end

  assign fd_cur    = fd[g];
  assign bu_cur    = bu[g];
  assign last_slot = ((SW+1)'(s) + (SW+1)'(1)) == (SW+1)'({bu_cur, 2'b00});
  assign last_w    = (w == (n - 3'd1));
  assign key_eq    = (key_q == in_key[w]);
  assign hash_hit  = (res_q != 32'd0) && ((hash_q & mask) == (h & mask));
  assign slot_new  = SW'({bu_cur, w[1:0]});

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hot_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (bu[g_in] == '0) ? hot_pkg::ST_MISS : hot_pkg::ST_RES;
        end
      end
      hot_pkg::ST_RES: state_next = hot_pkg::ST_SLOT;
      hot_pkg::ST_SLOT: begin
        if ((fn == hot_pkg::FN_REFILL) ? hash_hit : (res_q != 32'd0)) begin
          state_next = hot_pkg::ST_KRD;
        end else begin
          state_next = last_slot ? hot_pkg::ST_MISS : hot_pkg::ST_RES;
        end
      end
      hot_pkg::ST_KRD: state_next = hot_pkg::ST_KCMP;
      hot_pkg::ST_KCMP: begin
        if (fn != hot_pkg::FN_REFILL && !key_eq) begin
          state_next = last_slot ? hot_pkg::ST_MISS : hot_pkg::ST_RES;
        end else begin
          state_next = last_w ? hot_pkg::ST_HIT : hot_pkg::ST_KRD;
        end
      end
      hot_pkg::ST_HIT: state_next = hot_pkg::ST_OUT;
      hot_pkg::ST_MISS: begin
        if (fn == hot_pkg::FN_SET && fd_cur == '0 && bu_cur != BUW'(BKT)) begin
          state_next = hot_pkg::ST_GROW;
        end else if (fn == hot_pkg::FN_SET && fd_cur != '0) begin
          state_next = hot_pkg::ST_POP;
        end else begin
          state_next = hot_pkg::ST_OUT;
        end
      end
      hot_pkg::ST_GROW: begin
        if (w[1:0] == 2'd3) begin
          state_next = hot_pkg::ST_POP;
        end
      end
      hot_pkg::ST_POP: state_next = hot_pkg::ST_INS;
      hot_pkg::ST_INS: state_next = hot_pkg::ST_KWR;
      hot_pkg::ST_KWR: begin
        if (last_w) begin
          state_next = hot_pkg::ST_OUT;
        end
      end
      hot_pkg::ST_OUT: state_next = hot_pkg::ST_IDLE;
      default: state_next = hot_pkg::ST_IDLE;
    endcase
  end

  // memory requests
  always_comb begin
    we         = '0;
    res_waddr  = {g, s};
    res_wdata  = nr;
    hash_wdata = h;
    res_raddr  = {g, s};
    key_waddr  = {g, s, w};
    key_wdata  = in_key[w];
    key_raddr  = {g, s, w};
    fs_waddr   = {g, SW'(fd_cur)};
    fs_wdata   = s;
    fs_raddr   = {g, SW'(fd_cur - FDW'(1))};
    case (state)
      hot_pkg::ST_HIT: begin
        if (fn == hot_pkg::FN_SET) begin
          we.res  = 1'b1;
          we.hash = 1'b1;
        end else if (fn != hot_pkg::FN_GET) begin
          we.res    = 1'b1;
          res_wdata = 32'd0;
          we.fs     = (fd_cur != FDW'(SLOTS_PER_GROUP));
        end
      end
      hot_pkg::ST_GROW: begin
        // fresh bucket: clear its results and stack its slots
        we.res    = 1'b1;
        res_waddr = {g, slot_new};
        res_wdata = 32'd0;
        we.fs     = 1'b1;
        fs_waddr  = {g, SW'(w[1:0])};
        fs_wdata  = slot_new;
      end
      hot_pkg::ST_INS: begin
        we.res    = 1'b1;
        we.hash   = 1'b1;
        res_waddr = {g, fs_q};
      end
      hot_pkg::ST_KWR: we.key = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= hot_pkg::ST_IDLE;
      log2_cap <= hot_pkg::CAP_RESET;
      kwc      <= hot_pkg::KWC_RESET;
      occ      <= '0;
      for (int i = 0; i < hot_pkg::GROUPS; i++) begin
        fd[i] <= '0;
        bu[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          hot_pkg::REG_LOG2_CAP:  log2_cap <= cfg_data;
          hot_pkg::REG_KEY_WORDS: kwc <= cfg_data[KW-1:0];
          default: ;
        endcase
      end
      case (state)
        hot_pkg::ST_HIT: begin
          if (fn == hot_pkg::FN_UNSET || fn == hot_pkg::FN_REFILL) begin
            if (fd_cur != FDW'(SLOTS_PER_GROUP)) begin
              fd[g] <= fd_cur + FDW'(1);
            end
            if (occ != '0) begin
              occ <= occ - CW'(1);
            end
          end
        end
        hot_pkg::ST_GROW: begin
          if (w[1:0] == 2'd3) begin
            fd[g] <= FDW'(hot_pkg::LANES);
            bu[g] <= bu_cur + BUW'(1);
          end
        end
        hot_pkg::ST_POP: fd[g] <= fd_cur - FDW'(1);
        hot_pkg::ST_INS: begin
          if (occ != CW'(TOTAL)) begin
            occ <= occ + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      hot_pkg::ST_IDLE: begin
        if (accept) begin
          fn      <= (func == hot_pkg::FN_SET && store_value == 32'd0) ?
                     hot_pkg::FN_GET : hot_pkg::func_t'(func);
          h       <= lookup_hash;
          nr      <= store_value;
          mask    <= mask_in;
          in_key  <= key_in;
          g       <= g_in;
          n       <= n_in;
          s       <= '0;
          w       <= '0;
          res_out <= 32'd0;
          found_q <= 1'b0;
          full_q  <= 1'b0;
          for (int i = 0; i < hot_pkg::MAX_KEY_WORDS; i++) begin
            kout[i] <= 32'd0;
          end
        end
      end
      hot_pkg::ST_SLOT: begin
        w <= '0;
        if (fn == hot_pkg::FN_REFILL ? !hash_hit : (res_q == 32'd0)) begin
          s <= s + SW'(1);
        end
      end
      hot_pkg::ST_KCMP: begin
        if (fn == hot_pkg::FN_REFILL) begin
          kout[w] <= key_q;
          w       <= w + 3'd1;
          if (last_w) begin
            res_out <= res_q;
            found_q <= 1'b1;
          end
        end else if (!key_eq) begin
          s <= s + SW'(1);
        end else begin
          w <= w + 3'd1;
          if (last_w) begin
            res_out <= res_q;
            found_q <= 1'b1;
          end
        end
      end
      hot_pkg::ST_MISS: begin
        w <= '0;
        if (fn == hot_pkg::FN_SET && fd_cur == '0 && bu_cur == BUW'(BKT)) begin
          full_q <= 1'b1;
        end
      end
      hot_pkg::ST_GROW: w <= w + 3'd1;
      hot_pkg::ST_INS: begin
        s <= fs_q;
        w <= '0;
      end
      hot_pkg::ST_KWR: w <= w + 3'd1;
      default: ;
    endcase
  end

  assign busy        = (state != hot_pkg::ST_IDLE);
  assign done        = (state == hot_pkg::ST_OUT);
  assign out_result  = res_out;
  assign found       = found_q;
  assign table_full  = full_q;
  assign key_out     = kout;
  assign entry_total = 11'(occ);

endmodule

// File: design/hash_overflow_table.sv
// top level of the hash table overflow store
// a transaction steps through accept, a slot read and check per scanned slot, a key read
//   and compare per key word, hit update and result; a set that inserts adds bucket
//   growth when its free list is empty, the free stack pop and a write per key word
// one transaction at a time: start is taken only while busy is low
// throughput is set by the single shared slot read and key compare path
// rst is synchronous: free lists and counts empty, registers back to defaults
module hash_overflow_table #(
  parameter int SLOTS_PER_GROUP = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic [1:0]  func,
  input  logic [31:0] lookup_hash,
  input  logic [31:0] store_value,
  input  logic [31:0] key_word_0,
  input  logic [31:0] key_word_1,
  input  logic [31:0] key_word_2,
  input  logic [31:0] key_word_3,
  input  logic [31:0] key_word_4,
  input  logic [31:0] key_word_5,
  output logic [31:0] out_result,
  output logic        found,
  output logic        table_full,
  output logic [31:0] out_key_0,
  output logic [31:0] out_key_1,
  output logic [31:0] out_key_2,
  output logic [31:0] out_key_3,
  output logic [31:0] out_key_4,
  output logic [31:0] out_key_5,
  output logic [10:0] entry_total
);

  localparam int SW = $clog2(SLOTS_PER_GROUP);
  localparam int IW = hot_pkg::GW + SW;

  logic [31:0]      key_in  [hot_pkg::MAX_KEY_WORDS];
  logic [31:0]      key_out [hot_pkg::MAX_KEY_WORDS];
  hot_pkg::mem_we_t we;
  logic [IW-1:0]    res_waddr, res_raddr, fs_waddr, fs_raddr;
  logic [IW+2:0]    key_waddr, key_raddr;
  logic [31:0]      res_wdata, hash_wdata, res_q, hash_q, key_wdata, key_q;
  logic [SW-1:0]    fs_wdata, fs_q;

  assign key_in[0] = key_word_0;
  assign key_in[1] = key_word_1;
  assign key_in[2] = key_word_2;
  assign key_in[3] = key_word_3;
  assign key_in[4] = key_word_4;
  assign key_in[5] = key_word_5;
  assign out_key_0 = key_out[0];
  assign out_key_1 = key_out[1];
  assign out_key_2 = key_out[2];
  assign out_key_3 = key_out[3];
  assign out_key_4 = key_out[4];
  assign out_key_5 = key_out[5];

  hot_ctrl #(
    .SLOTS_PER_GROUP(SLOTS_PER_GROUP)
  ) u_ctrl (
    .clk, .rst, .start, .busy, .done, .cfg_we, .cfg_index, .cfg_data,
    .func, .lookup_hash, .store_value, .key_in, .out_result, .found, .table_full,
    .key_out, .entry_total, .we, .res_waddr, .res_wdata, .hash_wdata, .res_raddr,
    .res_q, .hash_q, .key_waddr, .key_wdata, .key_raddr, .key_q, .fs_waddr,
    .fs_wdata, .fs_raddr, .fs_q
  );

  hot_store #(
    .IW(IW)
  ) u_store (
    .clk, .we, .res_waddr, .res_wdata, .hash_wdata, .res_raddr, .res_q, .hash_q,
    .key_waddr, .key_wdata, .key_raddr, .key_q, .fs_waddr, .fs_wdata, .fs_raddr,
    .fs_q
  );

endmodule

// File: design/hot_chk.sv
// port level checks of the hash overflow table
module hot_chk (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        found,
  input logic        table_full,
  input logic [31:0] out_result
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  a_done_ends: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy after done");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transaction not started");

  a_full_miss: assert property (@(posedge clk) disable iff (rst)
    (done && table_full) |-> !found)
    else $error("full and found together");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (out_result == 32'd0))
    else $error("result on a miss");

endmodule

bind hash_overflow_table hot_chk u_chk (
  .clk, .rst, .start, .busy, .done, .found, .table_full, .out_result
);

// File: tb/tb_top.sv
// self-checking testbench of the hash table overflow store
`timescale 1ns / 100ps

module tb_top;

  localparam int SPG      = 64;
  localparam int NSLOT    = hot_pkg::GROUPS * SPG;
  localparam int WD_LIMIT = 20000;
  localparam int TAIL     = 150;

  typedef struct {
    hot_pkg::func_t    fn;
    logic [31:0]       h;
    logic [31:0]       nr;
    logic [5:0][31:0]  kw;
  } op_t;

  typedef struct {
    logic [31:0]       res;
    logic              hit;
    logic              full;
    logic [5:0][31:0]  keys;
    logic [10:0]       total;
  } answer_t;

  typedef struct {
    hot_pkg::func_t fn;
    logic [31:0]    h;
    logic [31:0]    nr;
    logic [31:0]    k0;
    bit             typed;
    logic [31:0]    eres;
    logic           ehit;
    logic [31:0]    ekey;
    logic [10:0]    etotal;
  } dir_row_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done;
  logic cfg_we = 0;
  logic [0:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;
  logic [1:0] func = '0;
  logic [31:0] lookup_hash = '0, store_value = '0;
  logic [31:0] key_word_0 = '0, key_word_1 = '0, key_word_2 = '0;
  logic [31:0] key_word_3 = '0, key_word_4 = '0, key_word_5 = '0;
  logic [31:0] out_result, out_key_0, out_key_1, out_key_2, out_key_3, out_key_4, out_key_5;
  logic found, table_full;
  logic [10:0] entry_total;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  hash_overflow_table dut (.*);

  // shadow copy of the store
  logic [31:0]      sh_res [NSLOT];
  logic [31:0]      sh_hash [NSLOT];
  logic [5:0][31:0] sh_key [NSLOT];
  int               sh_nw [NSLOT];
  int               sh_free [NSLOT];
  int               sh_depth [hot_pkg::GROUPS];
  int               sh_bused [hot_pkg::GROUPS];
  int               sh_occ;
  logic [4:0]       sh_cap;
  logic [2:0]       sh_kwc;

  answer_t pending_results[$];
  int      n_errors = 0;
  int      quiet_cycles = 0;
  int      n_sent = 0;

  function automatic int eff_words(logic [2:0] c);
    return (c == 0) ? 1 : (c > 6) ? 6 : int'(c);
  endfunction

  function automatic logic [31:0] cap_mask();
    int l;
    l = (sh_cap < 2) ? 2 : int'(sh_cap);
    return 32'(((64'd1 << l) - 64'd1) & ~64'd3);
  endfunction

  function automatic int match_slot(int g, op_t op, int n);
    int idx;
    bit eq;
    for (int b = 0; b < sh_bused[g] && b < SPG / hot_pkg::LANES; b++)
      for (int l = 0; l < hot_pkg::LANES; l++) begin
        idx = g * SPG + b * hot_pkg::LANES + l;
        eq = sh_res[idx] != 0;
        for (int w = 0; w < n; w++)
          if (sh_key[idx][w] != op.kw[w]) eq = 0;
        if (eq) return b * hot_pkg::LANES + l;
      end
    return -1;
  endfunction

  function automatic void free_slot(int g, int s, logic [31:0] h);
    sh_res[g * SPG + s] = '0;
    sh_hash[g * SPG + s] = ~h;
    if (sh_depth[g] < SPG) begin
      sh_free[g * SPG + sh_depth[g]] = s;
      sh_depth[g]++;
    end
    if (sh_occ > 0) sh_occ--;
  endfunction

  function automatic answer_t model_table_op(op_t op);
    answer_t a;
    int n, g, base, m, idx, s;
    logic [31:0] msk;
    bit hit;
    a = '{default: '0};
    n = eff_words(sh_kwc);
    msk = cap_mask();
    g = int'(((op.h & msk) >> 2) & 32'hf);
    base = g * SPG;
    hit = 0;
    case (op.fn)
      hot_pkg::FN_REFILL: begin
        for (int b = 0; b < sh_bused[g] && !hit; b++)
          for (int l = 0; l < hot_pkg::LANES && !hit; l++) begin
            idx = base + b * hot_pkg::LANES + l;
            if (sh_res[idx] != 0 && (sh_hash[idx] & msk) == (op.h & msk)) begin
              a.res = sh_res[idx];
              a.hit = 1;
              for (int w = 0; w < n; w++) a.keys[w] = sh_key[idx][w];
              free_slot(g, b * hot_pkg::LANES + l, op.h);
              hit = 1;
            end
          end
      end
      hot_pkg::FN_UNSET: begin
        m = match_slot(g, op, n);
        if (m >= 0) begin
          a.res = sh_res[base + m];
          a.hit = 1;
          free_slot(g, m, op.h);
        end
      end
      hot_pkg::FN_SET: begin
        m = match_slot(g, op, n);
        if (op.nr == 0) begin
          if (m >= 0) begin
            a.res = sh_res[base + m];
            a.hit = 1;
          end
        end else if (m >= 0) begin
          a.res = sh_res[base + m];
          a.hit = 1;
          sh_res[base + m] = op.nr;
          sh_hash[base + m] = op.h;
        end else begin
          // grow the free list one bucket at a time
          if (sh_depth[g] == 0 && sh_bused[g] < SPG / hot_pkg::LANES) begin
            for (int j = 0; j < hot_pkg::LANES; j++)
              sh_free[base + j] = sh_bused[g] * hot_pkg::LANES + j;
            sh_depth[g] = hot_pkg::LANES;
            sh_bused[g]++;
          end
          if (sh_depth[g] == 0) a.full = 1;
          else begin
            sh_depth[g]--;
            s = sh_free[base + sh_depth[g]] % SPG;
            idx = base + s;
            sh_res[idx] = op.nr;
            sh_hash[idx] = op.h;
            for (int w = 0; w < n; w++) sh_key[idx][w] = op.kw[w];
            sh_nw[idx] = n;
            if (sh_occ < NSLOT) sh_occ++;
          end
        end
      end
      default: begin
        m = match_slot(g, op, n);
        if (m >= 0) begin
          a.res = sh_res[base + m];
          a.hit = 1;
        end
      end
    endcase
    a.total = 11'(sh_occ);
    return a;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    n_errors++;
  endtask

  // issue one transaction; returns at the edge where it was taken
  task automatic issue(op_t op, bit typed, answer_t typed_ans);
    answer_t a;
    start <= 1;
    func <= op.fn;
    lookup_hash <= op.h;
    store_value <= op.nr;
    key_word_0 <= op.kw[0];
    key_word_1 <= op.kw[1];
    key_word_2 <= op.kw[2];
    key_word_3 <= op.kw[3];
    key_word_4 <= op.kw[4];
    key_word_5 <= op.kw[5];
    do @(posedge clk); while (busy);
    a = model_table_op(op);
    pending_results.push_back(typed ? typed_ans : a);
    n_sent++;
  endtask

  task automatic wait_drained();
    start <= 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [4:0] val);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == hot_pkg::REG_LOG2_CAP) sh_cap = val;
    else sh_kwc = val[2:0];
  endtask

  // unset everything by key so that raising the word count never exposes unwritten words;
  // a wide mask makes every group reachable
  task automatic empty_store();
    op_t op;
    answer_t none;
    logic [4:0] cap_keep;
    none = '{default: '0};
    cap_keep = sh_cap;
    write_reg(hot_pkg::REG_LOG2_CAP, 5'd31);
    while (sh_occ > 0) begin
      op = '{fn: hot_pkg::FN_UNSET, h: '0, nr: '0, kw: '0};
      for (int i = NSLOT - 1; i >= 0; i--)
        if (sh_res[i] != 0) begin
          op.h = 32'((i / SPG) << 2);
          op.kw = sh_key[i];
        end
      issue(op, 0, none);
    end
    start <= 0;
    write_reg(hot_pkg::REG_LOG2_CAP, cap_keep);
  endtask

  always @(posedge clk) begin
    answer_t e;
    logic [31:0] got_keys [6];
    if (!rst && done) begin
      got_keys = '{out_key_0, out_key_1, out_key_2, out_key_3, out_key_4, out_key_5};
      if (pending_results.size() == 0) begin
        $display("%0t result with no transaction outstanding", $realtime);
        n_errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_result !== e.res) report("out_result", out_result, e.res);
        if (found !== e.hit) report("found", 32'(found), 32'(e.hit));
        if (table_full !== e.full) report("table_full", 32'(table_full), 32'(e.full));
        for (int w = 0; w < 6; w++)
          if (got_keys[w] !== e.keys[w])
            report($sformatf("out_key_%0d", w), got_keys[w], e.keys[w]);
        if (entry_total !== e.total) report("entry_total", 32'(entry_total), 32'(e.total));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  dir_row_t dir_rows [11];
  logic [31:0]      pool_hash [128];
  logic [5:0][31:0] pool_key [128];

  initial begin
    op_t op;
    answer_t ta;
    int pool_n, set_pct, r, k, n_items, total_items, min_nw;
    logic [4:0] caps [9];
    logic [2:0] kwcs [9];

    for (int i = 0; i < NSLOT; i++) begin
      sh_res[i] = '0;
      sh_hash[i] = '0;
      sh_key[i] = '0;
      sh_nw[i] = 0;
      sh_free[i] = 0;
    end
    for (int g = 0; g < hot_pkg::GROUPS; g++) begin
      sh_depth[g] = 0;
      sh_bused[g] = 0;
    end
    sh_occ = 0;
    sh_cap = hot_pkg::CAP_RESET;
    sh_kwc = hot_pkg::KWC_RESET;

    dir_rows = '{
      '{hot_pkg::FN_GET,    32'h0,        32'h0,        32'h0,        1, 32'h0,
        0, 32'h0, 11'd0},
      '{hot_pkg::FN_UNSET,  32'h0,        32'h0,        32'h0,        1, 32'h0,
        0, 32'h0, 11'd0},
      '{hot_pkg::FN_REFILL, 32'hffffffff, 32'h0,        32'h0,        1, 32'h0,
        0, 32'h0, 11'd0},
      '{hot_pkg::FN_SET,    32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 32'h0,
        0, 32'h0, 11'd1},
      '{hot_pkg::FN_GET,    32'hffffffff, 32'h0,        32'hffffffff, 1, 32'hffffffff,
        1, 32'h0, 11'd1},
      '{hot_pkg::FN_SET,    32'hffffffff, 32'h1,        32'hffffffff, 1, 32'hffffffff,
        1, 32'h0, 11'd1},
      // set of zero answers like a get
      '{hot_pkg::FN_SET,    32'hffffffff, 32'h0,        32'hffffffff, 1, 32'h1,
        1, 32'h0, 11'd1},
      '{hot_pkg::FN_SET,    32'h0,        32'h5,        32'h0,        0, 32'h0,
        0, 32'h0, 11'd0},
      '{hot_pkg::FN_REFILL, 32'hffffffff, 32'h0,        32'h0,        1, 32'h1,
        1, 32'hffffffff, 11'd1},
      '{hot_pkg::FN_UNSET,  32'h0,        32'h0,        32'h0,        1, 32'h5,
        1, 32'h0, 11'd0},
      '{hot_pkg::FN_GET,    32'h0,        32'h0,        32'h0,        0, 32'h0,
        0, 32'h0, 11'd0}
    };

    // small capacity, out-of-range word counts and the extremes among the settings
    caps = '{5'd2, 5'd31, 5'd0, 5'd5, 5'd1, 5'd12, 5'd20, 5'd3, 5'd31};
    kwcs = '{3'd1, 3'd6, 3'd3, 3'd7, 3'd0, 3'd2, 3'd4, 3'd5, 3'd1};
    total_items = 1350;

    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      op = '{fn: dir_rows[i].fn, h: dir_rows[i].h, nr: dir_rows[i].nr,
             kw: {6{dir_rows[i].k0}}};
      ta = '{res: dir_rows[i].eres, hit: dir_rows[i].ehit, full: 1'b0,
             keys: {160'h0, dir_rows[i].ekey}, total: dir_rows[i].etotal};
      issue(op, dir_rows[i].typed, ta);
    end

    foreach (caps[p]) begin
      write_reg(hot_pkg::REG_LOG2_CAP, caps[p]);
      min_nw = 6;
      for (int i = 0; i < NSLOT; i++)
        if (sh_res[i] != 0 && sh_nw[i] < min_nw) min_nw = sh_nw[i];
      if (eff_words(kwcs[p]) > min_nw) empty_store();
      write_reg(hot_pkg::REG_KEY_WORDS, 5'(kwcs[p]));

      pool_n = (p % 3 == 0) ? 100 : $urandom_range(6, 40);
      set_pct = (p % 3 == 0) ? 80 : 40;
      for (int i = 0; i < pool_n; i++) begin
        pool_hash[i] = $urandom;
        for (int w = 0; w < 6; w++) pool_key[i][w] = $urandom;
        // shared first words give several matches once the word count drops
        if (i % 2 == 1) pool_key[i][0] = $urandom_range(0, 7);
      end

      n_items = 150;
      for (int i = 0; i < n_items; i++) begin
        k = $urandom_range(0, pool_n - 1);
        r = $urandom_range(0, 99);
        op.fn = (r < set_pct) ? hot_pkg::FN_SET :
                (r < set_pct + (100 - set_pct) / 3) ? hot_pkg::FN_GET :
                (r < set_pct + 2 * (100 - set_pct) / 3) ? hot_pkg::FN_UNSET :
                hot_pkg::FN_REFILL;
        op.h = ($urandom_range(0, 9) == 0) ? $urandom : pool_hash[k];
        r = $urandom_range(0, 99);
        op.nr = (r < 4) ? 32'h0 : (r < 7) ? 32'hffffffff : $urandom;
        op.kw = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom} : pool_key[k];
        issue(op, 0, ta);
        if (i == n_items / 2 && n_sent < total_items - TAIL) wait_drained();
        else if (n_sent < total_items - TAIL && $urandom_range(0, 5) == 0) begin
          start <= 0;
          repeat ($urandom_range(1, 15)) @(posedge clk);
        end
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (n_errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
